@@ rtl/assert_macros.svh @@
// Assertion macros used by the lexer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define CSL_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition leads to a consequence in the next cycle, outside reset.
`define CSL_IMPLY_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/csl_pkg.sv @@
// Types and constants of the character stream lexer.
package csl_pkg;

  localparam logic [2:0] KIND_NONE   = 3'd0;
  localparam logic [2:0] KIND_STRING = 3'd1;
  localparam logic [2:0] KIND_NUMBER = 3'd2;
  localparam logic [2:0] KIND_OP     = 3'd3;
  localparam logic [2:0] KIND_END    = 3'd4;

  localparam logic [7:0] CH_POINT  = 8'h2E;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;

  localparam logic [15:0] SAT16 = 16'hFFFF;

  typedef struct packed {
    logic [2:0]  kind;
    logic        ok;
    logic [15:0] line;
    logic [15:0] column;
    logic [31:0] offset;
    logic [15:0] length;
    logic        last;
  } token_t;

  function automatic logic [15:0] inc_sat(input logic [15:0] v);
    return (v == SAT16) ? v : v + 16'd1;
  endfunction

endpackage

@@ rtl/char_stream_lexer.sv @@
// Top level of the character stream lexer.
// One character (or an end-of-text mark) is taken per cycle while in_ready_o is
// high and is classified combinationally against the scan state. The tokens it
// completes, at most two per item, go into a three-entry result queue that
// drains one token per cycle while out_ready_i is high. The input is ready while
// the queue can hold two more tokens, so plain text runs at one item per cycle
// when the receiver keeps up. Line, column and length saturate at 65535; the
// offset wraps at 32 bits.
`include "assert_macros.svh"

module char_stream_lexer import csl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_code_i,
  input  logic        end_of_text_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  token_kind_o,
  output logic        ok_o,
  output logic [15:0] start_line_o,
  output logic [15:0] start_column_o,
  output logic [31:0] start_offset_o,
  output logic [15:0] token_length_o,
  output logic        last_o
);

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_IDENT  = 3'd1,
    MODE_NUMBER = 3'd2,
    MODE_STRING = 3'd3,
    MODE_ESCAPE = 3'd4
  } mode_e;

  mode_e       mode_q, mode_d;
  logic [7:0]  quote_q, quote_d;
  logic        saw_digit_q, saw_digit_d;
  logic        saw_point_q, saw_point_d;
  logic [15:0] cur_line_q, cur_line_d;
  logic [15:0] cur_col_q, cur_col_d;
  logic [31:0] cur_off_q, cur_off_d;
  logic [15:0] tok_line_q, tok_line_d;
  logic [15:0] tok_col_q, tok_col_d;
  logic [31:0] tok_off_q, tok_off_d;
  logic [15:0] tok_cnt_q, tok_cnt_d;

  token_t      slot_q [3];
  token_t      slot_d [3];
  logic [1:0]  cnt_q, cnt_d;

  logic        acc, pop;
  logic [1:0]  n_new;
  token_t      res0, res1;
  logic [2:0]  cnt_sum;

  // character classes
  logic [7:0] c;
  logic is_dec, is_alpha, is_space, is_numch, is_id_first, is_id_more, is_opdelim;
  logic is_quote;

  assign c           = char_code_i;
  assign is_dec      = (c inside {[8'h30:8'h39]});
  assign is_alpha    = (c inside {[8'h61:8'h7A], [8'h41:8'h5A]});
  assign is_space    = (c inside {8'h20, 8'h09, 8'h0B, 8'h0C, 8'h0D});
  assign is_numch    = is_dec || (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_POINT);
  assign is_id_first = is_alpha || (c == CH_UNDER);
  assign is_id_more  = is_alpha || is_dec || (c == CH_UNDER) || (c == CH_COLON);
  assign is_quote    = (c == CH_DQUOTE) || (c == CH_SQUOTE);
  assign is_opdelim  = (c inside {8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h3D, 8'h3C, 8'h3E,
                                  8'h21, 8'h26, 8'h7C, 8'h5E, 8'h25, 8'h7E,
                                  8'h28, 8'h29, 8'h7B, 8'h7D, 8'h5B, 8'h5D, 8'h3B,
                                  8'h3A, 8'h2C, 8'h2E, 8'h23});

  // handling of a character with no token pending
  mode_e       fr_mode;
  logic        fr_start, fr_emit;
  logic [15:0] fr_col, fr_cnt;
  logic [31:0] fr_off;
  token_t      fr_tok;

  always_comb begin
    fr_mode  = MODE_IDLE;
    fr_start = 1'b0;
    fr_emit  = 1'b0;
    fr_col   = cur_col_q;
    fr_off   = cur_off_q;
    fr_cnt   = 16'd1;
    fr_tok   = '{kind: is_opdelim ? KIND_OP : KIND_NONE, ok: 1'b1, line: cur_line_q,
                 column: cur_col_q, offset: cur_off_q, length: 16'd1, last: 1'b0};
    if (is_space) begin
      fr_mode = MODE_IDLE;
    end else if (is_quote) begin
      fr_mode  = MODE_STRING;
      fr_start = 1'b1;
      fr_col   = inc_sat(cur_col_q);
      fr_off   = cur_off_q + 32'd1;
      fr_cnt   = 16'd0;
    end else if (is_numch) begin
      fr_mode  = MODE_NUMBER;
      fr_start = 1'b1;
    end else if (is_id_first) begin
      fr_mode  = MODE_IDENT;
      fr_start = 1'b1;
    end else begin
      fr_emit  = 1'b1;
    end
  end

  // scan step
  token_t pend;
  logic   pend_emit, use_fresh;

  always_comb begin
    mode_d      = mode_q;
    quote_d     = quote_q;
    saw_digit_d = saw_digit_q;
    saw_point_d = saw_point_q;
    cur_line_d  = cur_line_q;
    cur_col_d   = cur_col_q;
    cur_off_d   = cur_off_q;
    tok_line_d  = tok_line_q;
    tok_col_d   = tok_col_q;
    tok_off_d   = tok_off_q;
    tok_cnt_d   = tok_cnt_q;
    pend_emit   = 1'b0;
    use_fresh   = 1'b0;
    pend        = '{kind: KIND_STRING, ok: 1'b1, line: tok_line_q, column: tok_col_q,
                    offset: tok_off_q, length: tok_cnt_q, last: 1'b0};
    n_new       = 2'd0;
    res0        = pend;
    res1        = pend;

    if (end_of_text_i) begin
      case (mode_q)
        MODE_IDENT: begin
          pend_emit = 1'b1;
        end
        MODE_NUMBER: begin
          pend_emit = 1'b1;
          pend.kind = KIND_NUMBER;
          pend.ok   = saw_digit_q;
        end
        MODE_STRING, MODE_ESCAPE: begin
          pend_emit = 1'b1;
          pend.ok   = 1'b0;
        end
        default: begin
          pend_emit = 1'b0;
        end
      endcase
      mode_d      = MODE_IDLE;
      saw_digit_d = 1'b0;
      saw_point_d = 1'b0;
      res0 = pend;
      res1 = '{kind: KIND_END, ok: 1'b0, line: cur_line_q, column: cur_col_q,
               offset: cur_off_q, length: 16'd0, last: 1'b1};
      if (pend_emit) begin
        n_new = 2'd2;
      end else begin
        n_new = 2'd1;
        res0  = res1;
      end
    end else begin
      case (mode_q)
        MODE_IDENT: begin
          if (is_id_more) begin
            tok_cnt_d = inc_sat(tok_cnt_q);
          end else begin
            pend_emit = 1'b1;
            use_fresh = 1'b1;
          end
        end
        MODE_NUMBER: begin
          if (is_numch) begin
            if ((c == CH_POINT) && saw_point_q) begin
              pend_emit   = 1'b1;
              pend.kind   = KIND_NUMBER;
              pend.ok     = 1'b0;
              pend.length = inc_sat(tok_cnt_q);
              mode_d      = MODE_IDLE;
              saw_digit_d = 1'b0;
              saw_point_d = 1'b0;
            end else begin
              tok_cnt_d = inc_sat(tok_cnt_q);
              if (is_dec) saw_digit_d = 1'b1;
              if (c == CH_POINT) saw_point_d = 1'b1;
            end
          end else begin
            pend_emit = 1'b1;
            pend.kind = KIND_NUMBER;
            pend.ok   = saw_digit_q;
            use_fresh = 1'b1;
          end
        end
        MODE_STRING: begin
          if (c == quote_q) begin
            pend_emit = 1'b1;
            mode_d    = MODE_IDLE;
          end else begin
            tok_cnt_d = inc_sat(tok_cnt_q);
            if (c == CH_BSLASH) mode_d = MODE_ESCAPE;
          end
        end
        MODE_ESCAPE: begin
          tok_cnt_d = inc_sat(tok_cnt_q);
          mode_d    = MODE_STRING;
        end
        default: begin
          use_fresh = 1'b1;
        end
      endcase

      if (use_fresh) begin
        mode_d = fr_mode;
        if (fr_start) begin
          tok_line_d = cur_line_q;
          tok_col_d  = fr_col;
          tok_off_d  = fr_off;
          tok_cnt_d  = fr_cnt;
        end
        if (fr_mode == MODE_STRING) quote_d = c;
        if (fr_mode == MODE_NUMBER) begin
          saw_digit_d = is_dec;
          saw_point_d = (c == CH_POINT);
        end
      end

      if (pend_emit && use_fresh && fr_emit) begin
        n_new     = 2'd2;
        res0      = pend;
        res1      = fr_tok;
        res1.last = 1'b1;
      end else if (pend_emit) begin
        n_new     = 2'd1;
        res0      = pend;
        res0.last = 1'b1;
      end else if (use_fresh && fr_emit) begin
        n_new     = 2'd1;
        res0      = fr_tok;
        res0.last = 1'b1;
      end

      cur_off_d = cur_off_q + 32'd1;
      if (c == CH_NL) begin
        cur_line_d = inc_sat(cur_line_q);
        cur_col_d  = 16'd1;
      end else begin
        cur_col_d  = inc_sat(cur_col_q);
      end
    end
  end

  // result queue
  assign out_valid_o = (cnt_q != 2'd0);
  assign pop         = out_valid_o && out_ready_i;
  assign in_ready_o  = (cnt_q < 2'd2) || ((cnt_q == 2'd2) && out_ready_i);
  assign acc         = in_valid_i && in_ready_o;
  assign cnt_sum     = {1'b0, cnt_q} + {1'b0, (acc ? n_new : 2'd0)} - {2'b0, pop};

  always_comb begin
    logic [2:0] j, k;
    for (int i = 0; i < 3; i++) begin
      j = 3'(i) + {2'b0, pop};
      k = j - {1'b0, cnt_q};
      slot_d[i] = slot_q[i];
      if (j < {1'b0, cnt_q}) begin
        slot_d[i] = slot_q[j[1:0]];
      end else if (acc && (k == 3'd0) && (n_new != 2'd0)) begin
        slot_d[i] = res0;
      end else if (acc && (k == 3'd1) && (n_new == 2'd2)) begin
        slot_d[i] = res1;
      end
    end
    cnt_d = cnt_sum[1:0];
  end

  assign token_kind_o   = slot_q[0].kind;
  assign ok_o           = slot_q[0].ok;
  assign start_line_o   = slot_q[0].line;
  assign start_column_o = slot_q[0].column;
  assign start_offset_o = slot_q[0].offset;
  assign token_length_o = slot_q[0].length;
  assign last_o         = slot_q[0].last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      quote_q     <= 8'd0;
      saw_digit_q <= 1'b0;
      saw_point_q <= 1'b0;
      cur_line_q  <= 16'd1;
      cur_col_q   <= 16'd1;
      cur_off_q   <= 32'd0;
      tok_line_q  <= 16'd0;
      tok_col_q   <= 16'd0;
      tok_off_q   <= 32'd0;
      tok_cnt_q   <= 16'd0;
      cnt_q       <= 2'd0;
    end else begin
      if (acc) begin
        mode_q      <= mode_d;
        quote_q     <= quote_d;
        saw_digit_q <= saw_digit_d;
        saw_point_q <= saw_point_d;
        cur_line_q  <= cur_line_d;
        cur_col_q   <= cur_col_d;
        cur_off_q   <= cur_off_d;
        tok_line_q  <= tok_line_d;
        tok_col_q   <= tok_col_d;
        tok_off_q   <= tok_off_d;
        tok_cnt_q   <= tok_cnt_d;
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      slot_q[i] <= slot_d[i];
    end
  end

  `CSL_ASSERT(a_queue_room, !(acc && cnt_sum[2]), "result queue overflow")
  `CSL_IMPLY_NEXT(a_eot_idle, acc && end_of_text_i, mode_q == MODE_IDLE,
                  "scan not idle after end of text")
  `CSL_IMPLY_NEXT(a_pos_hold, !acc, $stable(cur_off_q), "offset moved without an item")

endmodule

@@ sim/char_stream_lexer_tb.sv @@
// Self-checking testbench for char_stream_lexer: directed table and random text.
`timescale 1ns / 1ps

module char_stream_lexer_tb;
  import csl_pkg::*;

  typedef enum logic [2:0] {
    SCAN_IDLE, SCAN_WORD, SCAN_NUMBER, SCAN_QUOTED, SCAN_ESCAPE
  } scan_mode_e;

  typedef struct packed {
    logic [7:0] code;
    logic       eot;
    logic       typed;
    token_t     tok;
  } lex_row_t;

  localparam int unsigned HOLD_CYCLES = 200;
  localparam int unsigned TEXT_ITEMS  = 640;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  char_code_i = 8'h00;
  logic        end_of_text_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  token_kind_o;
  logic        ok_o;
  logic [15:0] start_line_o;
  logic [15:0] start_column_o;
  logic [31:0] start_offset_o;
  logic [15:0] token_length_o;
  logic        last_o;

  scan_mode_e  scan_st;
  logic [7:0]  open_quote;
  logic        had_digit, had_point;
  logic [15:0] at_line, at_col, tk_line, tk_col, tk_len;
  logic [31:0] at_off, tk_off;
  token_t      step_toks[$];
  token_t      tokens_due[$];
  lex_row_t    dir_rows[$];

  int unsigned items_in = 0;
  int unsigned bad_tokens = 0;
  bit          quiet_mode = 1'b0;
  bit          hold_sink = 1'b0;
  bit          sink_holding = 1'b0;

  char_stream_lexer dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .char_code_i    (char_code_i),
    .end_of_text_i  (end_of_text_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .token_kind_o   (token_kind_o),
    .ok_o           (ok_o),
    .start_line_o   (start_line_o),
    .start_column_o (start_column_o),
    .start_offset_o (start_offset_o),
    .token_length_o (token_length_o),
    .last_o         (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #15_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic [15:0] bump16(input logic [15:0] v);
    return (v == SAT16) ? v : v + 16'd1;
  endfunction

  function automatic logic is_dig(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0B || c == 8'h0C || c == 8'h0D;
  endfunction

  function automatic logic is_num_ch(input logic [7:0] c);
    return is_dig(c) || c == CH_PLUS || c == CH_MINUS || c == CH_POINT;
  endfunction

  function automatic logic is_word_ch(input logic [7:0] c);
    return is_letter(c) || is_dig(c) || c == CH_UNDER || c == CH_COLON;
  endfunction

  function automatic logic is_punct(input logic [7:0] c);
    case (c)
      8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h3D, 8'h3C, 8'h3E, 8'h21, 8'h26, 8'h7C, 8'h5E, 8'h25,
      8'h7E, 8'h28, 8'h29, 8'h7B, 8'h7D, 8'h5B, 8'h5D, 8'h3B, 8'h3A, 8'h2C, 8'h2E,
      8'h23: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  task automatic put_tok(input logic [2:0] k, input logic o, input logic [15:0] ln,
                         input logic [15:0] cl, input logic [31:0] of, input logic [15:0] len);
    token_t t;
    t.kind   = k;
    t.ok     = o;
    t.line   = ln;
    t.column = cl;
    t.offset = of;
    t.length = len;
    t.last   = 1'b0;
    step_toks.push_back(t);
  endtask

  task automatic close_tok(input logic [2:0] k, input logic o, input logic [15:0] len);
    scan_st = SCAN_IDLE;
    put_tok(k, o, tk_line, tk_col, tk_off, len);
  endtask

  task automatic open_tok(input logic [7:0] c);
    if (is_blank(c)) begin
    end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
      scan_st    = SCAN_QUOTED;
      open_quote = c;
      tk_line    = at_line;
      tk_col     = bump16(at_col);
      tk_off     = at_off + 32'd1;
      tk_len     = 16'd0;
    end else if (is_num_ch(c)) begin
      scan_st   = SCAN_NUMBER;
      had_digit = is_dig(c);
      had_point = (c == CH_POINT);
      tk_line   = at_line;
      tk_col    = at_col;
      tk_off    = at_off;
      tk_len    = 16'd1;
    end else if (is_letter(c) || c == CH_UNDER) begin
      scan_st = SCAN_WORD;
      tk_line = at_line;
      tk_col  = at_col;
      tk_off  = at_off;
      tk_len  = 16'd1;
    end else begin
      put_tok(is_punct(c) ? KIND_OP : KIND_NONE, 1'b1, at_line, at_col, at_off, 16'd1);
    end
  endtask

  task automatic scan_char(input logic [7:0] c, input logic e);
    token_t t;
    step_toks.delete();
    if (e) begin
      case (scan_st)
        SCAN_WORD:                close_tok(KIND_STRING, 1'b1, tk_len);
        SCAN_NUMBER:              close_tok(KIND_NUMBER, had_digit, tk_len);
        SCAN_QUOTED, SCAN_ESCAPE: close_tok(KIND_STRING, 1'b0, tk_len);
        default: ;
      endcase
      scan_st   = SCAN_IDLE;
      had_digit = 1'b0;
      had_point = 1'b0;
      put_tok(KIND_END, 1'b0, at_line, at_col, at_off, 16'd0);
    end else begin
      case (scan_st)
        SCAN_WORD: begin
          if (is_word_ch(c)) begin
            tk_len = bump16(tk_len);
          end else begin
            close_tok(KIND_STRING, 1'b1, tk_len);
            open_tok(c);
          end
        end
        SCAN_NUMBER: begin
          if (is_num_ch(c)) begin
            if (c == CH_POINT && had_point) begin
              close_tok(KIND_NUMBER, 1'b0, bump16(tk_len));
              had_digit = 1'b0;
              had_point = 1'b0;
            end else begin
              tk_len = bump16(tk_len);
              if (is_dig(c)) had_digit = 1'b1;
              if (c == CH_POINT) had_point = 1'b1;
            end
          end else begin
            close_tok(KIND_NUMBER, had_digit, tk_len);
            open_tok(c);
          end
        end
        SCAN_QUOTED: begin
          if (c == open_quote) begin
            close_tok(KIND_STRING, 1'b1, tk_len);
          end else begin
            tk_len = bump16(tk_len);
            if (c == CH_BSLASH) scan_st = SCAN_ESCAPE;
          end
        end
        SCAN_ESCAPE: begin
          tk_len  = bump16(tk_len);
          scan_st = SCAN_QUOTED;
        end
        default: begin
          scan_st = SCAN_IDLE;
          open_tok(c);
        end
      endcase
      at_off = at_off + 32'd1;
      if (c == CH_NL) begin
        at_line = bump16(at_line);
        at_col  = 16'd1;
      end else begin
        at_col = bump16(at_col);
      end
    end
    if (step_toks.size() > 0) begin
      t = step_toks.pop_back();
      t.last = 1'b1;
      step_toks.push_back(t);
    end
  endtask

  function automatic lex_row_t row(input logic [7:0] c, input logic e, input logic t,
                                   input logic [2:0] k, input logic o, input int unsigned ln,
                                   input int unsigned cl, input int unsigned of,
                                   input int unsigned len);
    lex_row_t r;
    r.code       = c;
    r.eot        = e;
    r.typed      = t;
    r.tok.kind   = k;
    r.tok.ok     = o;
    r.tok.line   = 16'(ln);
    r.tok.column = 16'(cl);
    r.tok.offset = 32'(of);
    r.tok.length = 16'(len);
    r.tok.last   = 1'b1;
    return r;
  endfunction

  function automatic int unsigned pause_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    else if (r < 90) return $urandom_range(3, 1);
    else if (r < 98) return $urandom_range(12, 4);
    else return $urandom_range(40, 20);
  endfunction

  function automatic logic [7:0] pick(input string s);
    return s[$urandom_range(s.len() - 1)];
  endfunction

  task automatic offer(input logic [7:0] c, input logic e, input logic typed, input token_t tok);
    in_valid_i    <= 1'b1;
    char_code_i   <= c;
    end_of_text_i <= e;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_in++;
    scan_char(c, e);
    if (typed) tokens_due.push_back(tok);
    else foreach (step_toks[i]) tokens_due.push_back(step_toks[i]);
  endtask

  task automatic sender_gap();
    int unsigned g;
    if (!quiet_mode) begin
      g = pause_len();
      if (g != 0) begin
        in_valid_i <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
    end
  endtask

  task automatic send(input logic [7:0] c, input logic e);
    offer(c, e, 1'b0, '0);
    sender_gap();
  endtask

  task automatic drain_tokens();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (tokens_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_word();
    int unsigned r, n;
    logic [7:0]  q, c;
    r = $urandom_range(99);
    if (r < 22) begin
      send(pick("abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_"), 1'b0);
      n = ($urandom_range(19) == 0) ? $urandom_range(40, 8) : $urandom_range(7);
      repeat (n) send(pick("aZqM_09:7bY"), 1'b0);
    end else if (r < 40) begin
      n = $urandom_range(6, 1);
      repeat (n) send(($urandom_range(9) < 6) ? pick("0123456789") : pick("+-."), 1'b0);
    end else if (r < 55) begin
      q = $urandom_range(1) ? CH_DQUOTE : CH_SQUOTE;
      send(q, 1'b0);
      n = $urandom_range(8);
      repeat (n) begin
        c = 8'($urandom_range(255));
        if ($urandom_range(6) == 0) begin
          send(CH_BSLASH, 1'b0);
          send(c, 1'b0);
        end else begin
          send((c == q) ? CH_POINT : c, 1'b0);
        end
      end
      if ($urandom_range(9) != 0) send(q, 1'b0);
    end else if (r < 70) begin
      send(pick("+-*/=<>!&|^%~(){}[];:,.#"), 1'b0);
    end else if (r < 80) begin
      case ($urandom_range(4))
        0: send(8'h20, 1'b0);
        1: send(8'h09, 1'b0);
        2: send(8'h0B, 1'b0);
        3: send(8'h0C, 1'b0);
        default: send(8'h0D, 1'b0);
      endcase
    end else if (r < 87) begin
      send(CH_NL, 1'b0);
    end else begin
      c = 8'($urandom_range(255));
      send(c, r >= 96);
    end
  endtask

  // Receiver: ready bursts and stalls, a long hold on request, always ready when quiet.
  initial begin : token_sink
    int unsigned n;
    forever begin
      if (hold_sink) begin
        hold_sink    = 1'b0;
        sink_holding = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        sink_holding = 1'b0;
      end else if (quiet_mode) begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(20, 1)) @(posedge clk_i);
        n = pause_len();
        if (n != 0) begin
          out_ready_i <= 1'b0;
          repeat (n) @(posedge clk_i);
        end
      end
    end
  end

  initial begin : token_check
    token_t got, want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        got.kind   = token_kind_o;
        got.ok     = ok_o;
        got.line   = start_line_o;
        got.column = start_column_o;
        got.offset = start_offset_o;
        got.length = token_length_o;
        got.last   = last_o;
        if (tokens_due.size() == 0) begin
          bad_tokens++;
          if (bad_tokens <= 10)
            $display("unexpected token: kind %0d ok %0b line %0d col %0d off %0d len %0d",
                     got.kind, got.ok, got.line, got.column, got.offset, got.length);
        end else begin
          want = tokens_due.pop_front();
          if (got.kind !== want.kind || got.ok !== want.ok || got.line !== want.line ||
              got.column !== want.column || got.offset !== want.offset ||
              got.length !== want.length || got.last !== want.last) begin
            bad_tokens++;
            if (bad_tokens <= 10) begin
              $display("token mismatch at %0t: got %0d/%0b/%0d/%0d/%0d/%0d/%0b",
                       $realtime, got.kind, got.ok, got.line, got.column, got.offset,
                       got.length, got.last);
              $display("  want %0d/%0b/%0d/%0d/%0d/%0d/%0b",
                       want.kind, want.ok, want.line, want.column,
                       want.offset, want.length, want.last);
            end
          end
        end
      end
    end
  end

  initial begin : stimulus
    lex_row_t r;
    bit       held;
    held       = 1'b0;
    scan_st    = SCAN_IDLE;
    open_quote = 8'h00;
    had_digit  = 1'b0;
    had_point  = 1'b0;
    at_line    = 16'd1;
    at_col     = 16'd1;
    at_off     = 32'd0;
    tk_line    = 16'd0;
    tk_col     = 16'd0;
    tk_off     = 32'd0;
    tk_len     = 16'd0;

    dir_rows.push_back(row(8'h28, 1'b0, 1'b1, KIND_OP, 1'b1, 1, 1, 0, 1));
    dir_rows.push_back(row(8'h80, 1'b0, 1'b1, KIND_NONE, 1'b1, 1, 2, 1, 1));
    dir_rows.push_back(row(8'hFF, 1'b0, 1'b1, KIND_NONE, 1'b1, 1, 3, 2, 1));
    dir_rows.push_back(row(8'h00, 1'b0, 1'b1, KIND_NONE, 1'b1, 1, 4, 3, 1));
    dir_rows.push_back(row(8'h20, 1'b0, 1'b0, KIND_NONE, 1'b0, 0, 0, 0, 0));
    dir_rows.push_back(row(8'h61, 1'b0, 1'b0, KIND_NONE, 1'b0, 0, 0, 0, 0));
    dir_rows.push_back(row(CH_COLON, 1'b0, 1'b0, KIND_NONE, 1'b0, 0, 0, 0, 0));
    dir_rows.push_back(row(8'h31, 1'b0, 1'b0, KIND_NONE, 1'b0, 0, 0, 0, 0));
    dir_rows.push_back(row(CH_PLUS, 1'b0, 1'b0, KIND_NONE, 1'b0, 0, 0, 0, 0));
    dir_rows.push_back(row(CH_POINT, 1'b0, 1'b0, KIND_NONE, 1'b0, 0, 0, 0, 0));
    dir_rows.push_back(row(CH_POINT, 1'b0, 1'b1, KIND_NUMBER, 1'b0, 1, 9, 8, 3));
    dir_rows.push_back(row(CH_MINUS, 1'b0, 1'b0, KIND_NONE, 1'b0, 0, 0, 0, 0));
    dir_rows.push_back(row(CH_NL, 1'b0, 1'b0, KIND_NONE, 1'b0, 0, 0, 0, 0));
    dir_rows.push_back(row(8'h37, 1'b0, 1'b0, KIND_NONE, 1'b0, 0, 0, 0, 0));
    dir_rows.push_back(row(CH_DQUOTE, 1'b0, 1'b0, KIND_NONE, 1'b0, 0, 0, 0, 0));
    dir_rows.push_back(row(CH_BSLASH, 1'b0, 1'b0, KIND_NONE, 1'b0, 0, 0, 0, 0));
    dir_rows.push_back(row(CH_DQUOTE, 1'b0, 1'b0, KIND_NONE, 1'b0, 0, 0, 0, 0));
    dir_rows.push_back(row(8'hC8, 1'b0, 1'b0, KIND_NONE, 1'b0, 0, 0, 0, 0));
    dir_rows.push_back(row(CH_DQUOTE, 1'b0, 1'b0, KIND_NONE, 1'b0, 0, 0, 0, 0));
    dir_rows.push_back(row(CH_SQUOTE, 1'b0, 1'b0, KIND_NONE, 1'b0, 0, 0, 0, 0));
    dir_rows.push_back(row(8'h78, 1'b0, 1'b0, KIND_NONE, 1'b0, 0, 0, 0, 0));
    dir_rows.push_back(row(8'h00, 1'b1, 1'b0, KIND_NONE, 1'b0, 0, 0, 0, 0));
    dir_rows.push_back(row(8'hA5, 1'b1, 1'b1, KIND_END, 1'b0, 2, 9, 21, 0));
    dir_rows.push_back(row(CH_UNDER, 1'b0, 1'b0, KIND_NONE, 1'b0, 0, 0, 0, 0));
    dir_rows.push_back(row(8'h09, 1'b0, 1'b0, KIND_NONE, 1'b0, 0, 0, 0, 0));
    dir_rows.push_back(row(CH_BSLASH, 1'b0, 1'b0, KIND_NONE, 1'b0, 0, 0, 0, 0));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      offer(r.code, r.eot, r.typed, r.tok);
      sender_gap();
    end

    while (items_in < TEXT_ITEMS) begin
      if ($urandom_range(15) == 0) quiet_mode = !quiet_mode;
      if (!held && items_in >= 320) begin
        // Stall the receiver and offer 60 items so that the input backs up, then drain.
        held = 1'b1;
        in_valid_i <= 1'b0;
        hold_sink = 1'b1;
        @(posedge clk_i);
        while (!sink_holding) @(posedge clk_i);
        repeat (60) offer($urandom_range(1) ? CH_NL : pick("(){};,#"), 1'b0, 1'b0, '0);
        drain_tokens();
      end
      send_word();
    end

    // Close the text with a delimiter and an end mark.
    quiet_mode = 1'b1;
    send(8'h3B, 1'b0);
    send(8'h5A, 1'b1);

    drain_tokens();
    repeat (20) @(posedge clk_i);
    if (bad_tokens == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/csl_pkg.sv
rtl/char_stream_lexer.sv
sim/char_stream_lexer_tb.sv
